@@ design/pkf2d_pkg.sv @@
// shared types, codes and fixed-point helpers for the 2d position kalman filter
// no dependencies
package pkf2d_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_SUM,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_EVAL,
    ST_DIV,
    ST_COMMIT,
    ST_OUT
  } state_e;

  // multiply jobs, run in this order
  typedef enum logic [3:0] {
    JOB_DET,
    JOB_M00,
    JOB_M01,
    JOB_M10,
    JOB_M11,
    JOB_PLAT,
    JOB_PLON,
    JOB_C00,
    JOB_C01,
    JOB_C10,
    JOB_C11
  } job_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_QLAT,
    REG_QLON,
    REG_QX,
    REG_RLAT,
    REG_RLON,
    REG_RX,
    REG_PINIT
  } cfg_reg_e;

  localparam int CfgIdxW = 3;
  localparam int DivW    = 64;  // gain numerator and determinant magnitude
  localparam int QuotW   = 31;  // gain magnitude

  localparam logic [30:0] QLatRst  = 31'd65536;
  localparam logic [30:0] QLonRst  = 31'd65536;
  localparam logic [31:0] QxRst    = 32'd0;
  localparam logic [30:0] RLatRst  = 31'd32768;
  localparam logic [30:0] RLonRst  = 31'd32768;
  localparam logic [31:0] RxRst    = 32'd0;
  localparam logic [30:0] PInitRst = 31'd65536000;

  localparam logic signed [66:0] Max32 = 67'sd2147483647;
  localparam logic signed [66:0] Min32 = -67'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > Max32) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Min32) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor((v + 2^29) / 2^30)
  function automatic logic signed [66:0] rnd30(input logic signed [66:0] v);
    logic signed [66:0] t;
    t = v + (67'sd1 <<< 29);
    return t >>> 30;
  endfunction

  function automatic logic signed [66:0] sx67(input logic signed [31:0] v);
    return {{35{v[31]}}, v};
  endfunction

  function automatic logic signed [66:0] ux67(input logic [30:0] v);
    return {36'd0, v};
  endfunction

endpackage

@@ design/position_kalman_filter_2d_core.sv @@
// 2d position kalman filter core: identity transition and observation, fixed point
// uses pkf2d_pkg and pkf2d_div
//
// channel | direction | signals                                  | transfer
// input   | in        | in_valid_i, in_ready_o, operation_i,    | valid & ready
//         |           | meas_lat_i, meas_lon_i                   |
// output  | out       | out_valid_o, out_ready_i, est_lat_o,    | valid & ready
//         |           | est_lon_o, singular_o                    |
// config  | in        | cfg_we_i, cfg_index_i, cfg_data_i        | we high, no wait
//
// predict: the covariance add in ST_PRED, then the output load in ST_OUT
// update: one 33x33 multiplier runs eleven two-product jobs through ST_MUL1, ST_MUL2,
//   ST_MUL3 and ST_EVAL, and a divider computes each gain entry in ST_DIV
// a singular noise sum ends the update after the determinant job
// reset loads the covariance diagonal with the initial variance, position zero
// the next input is taken as soon as the result sits in the output register
module position_kalman_filter_2d_core import pkf2d_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic signed [31:0]   meas_lat_i,
  input  logic signed [31:0]   meas_lon_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   est_lat_o,
  output logic signed [31:0]   est_lon_o,
  output logic                 singular_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  // control
  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic   out_valid_q, out_valid_d;
  logic   load_out;
  logic   div_start, div_done;
  logic   accept;

  // configuration
  logic [30:0]        qlat_q, qlon_q, rlat_q, rlon_q, pinit_q;
  logic signed [31:0] qx_q, rx_q;

  // filter state, P row major
  logic signed [31:0] p_q [4];
  logic signed [31:0] pos_lat_q, pos_lon_q;

  // working registers
  logic signed [31:0] s_q [4];   // noise sum
  logic signed [31:0] k_q [4];   // gain, q1.30
  logic signed [31:0] np_q [4];  // new covariance
  logic signed [31:0] npos_lat_q, npos_lon_q;
  logic signed [32:0] res_q [2]; // residual
  logic signed [65:0] prod_q;
  logic signed [66:0] acc_q;
  logic               det_neg_q, kneg_q, sing_q;
  logic [DivW-1:0]    det_mag_q;
  logic signed [31:0] est_lat_q, est_lon_q;
  logic               sing_out_q;

  // shared multiplier operands
  logic signed [32:0] a1, b1, a2, b2, mul_a, mul_b;
  logic               sub_mode, rnd_each;
  logic signed [65:0] prod_d;
  logic signed [66:0] prod_x, term, acc_abs;
  logic               acc_zero, acc_neg;
  logic [QuotW-1:0]   quot;

  function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  // per job: result = a1*b1 -/+ a2*b2
  always_comb begin
    a1 = '0; b1 = '0; a2 = '0; b2 = '0;
    sub_mode = 1'b0;
    rnd_each = 1'b0;
    case (job_q)
      JOB_DET: begin
        a1 = sx33(s_q[0]); b1 = sx33(s_q[3]); a2 = sx33(s_q[1]); b2 = sx33(s_q[2]);
        sub_mode = 1'b1;
      end
      // m = p * adj(s)
      JOB_M00: begin
        a1 = sx33(p_q[0]); b1 = sx33(s_q[3]); a2 = sx33(p_q[1]); b2 = sx33(s_q[2]);
        sub_mode = 1'b1;
      end
      JOB_M01: begin
        a1 = sx33(p_q[1]); b1 = sx33(s_q[0]); a2 = sx33(p_q[0]); b2 = sx33(s_q[1]);
        sub_mode = 1'b1;
      end
      JOB_M10: begin
        a1 = sx33(p_q[2]); b1 = sx33(s_q[3]); a2 = sx33(p_q[3]); b2 = sx33(s_q[2]);
        sub_mode = 1'b1;
      end
      JOB_M11: begin
        a1 = sx33(p_q[3]); b1 = sx33(s_q[0]); a2 = sx33(p_q[2]); b2 = sx33(s_q[1]);
        sub_mode = 1'b1;
      end
      // position terms are rounded one by one
      JOB_PLAT: begin
        a1 = sx33(k_q[0]); b1 = res_q[0]; a2 = sx33(k_q[1]); b2 = res_q[1];
        rnd_each = 1'b1;
      end
      JOB_PLON: begin
        a1 = sx33(k_q[2]); b1 = res_q[0]; a2 = sx33(k_q[3]); b2 = res_q[1];
        rnd_each = 1'b1;
      end
      // k * p with the old p
      JOB_C00: begin
        a1 = sx33(k_q[0]); b1 = sx33(p_q[0]); a2 = sx33(k_q[1]); b2 = sx33(p_q[2]);
      end
      JOB_C01: begin
        a1 = sx33(k_q[0]); b1 = sx33(p_q[1]); a2 = sx33(k_q[1]); b2 = sx33(p_q[3]);
      end
      JOB_C10: begin
        a1 = sx33(k_q[2]); b1 = sx33(p_q[0]); a2 = sx33(k_q[3]); b2 = sx33(p_q[2]);
      end
      JOB_C11: begin
        a1 = sx33(k_q[2]); b1 = sx33(p_q[1]); a2 = sx33(k_q[3]); b2 = sx33(p_q[3]);
      end
      default: begin
        a1 = '0;
      end
    endcase
  end

  assign mul_a  = (state_q == ST_MUL1) ? a1 : a2;
  assign mul_b  = (state_q == ST_MUL1) ? b1 : b2;
  assign prod_d = mul_a * mul_b;

  assign prod_x   = {prod_q[65], prod_q};
  assign term     = rnd_each ? rnd30(prod_x) : prod_x;
  assign acc_zero = (acc_q == '0);
  assign acc_neg  = acc_q[66];
  assign acc_abs  = acc_neg ? -acc_q : acc_q;

  assign accept   = in_valid_i && in_ready_o;
  assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    div_start   = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = operation_i ? ST_SUM : ST_PRED;
        end
      end
      ST_PRED: state_d = ST_OUT;
      ST_SUM: begin
        job_d   = JOB_DET;
        state_d = ST_MUL1;
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_EVAL;
      ST_EVAL: begin
        case (job_q)
          JOB_DET: begin
            if (acc_zero) begin
              state_d = ST_OUT;
            end else begin
              job_d   = job_e'(job_q + 4'd1);
              state_d = ST_MUL1;
            end
          end
          JOB_M00, JOB_M01, JOB_M10, JOB_M11: begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
          JOB_C11: state_d = ST_COMMIT;
          default: begin
            job_d   = job_e'(job_q + 4'd1);
            state_d = ST_MUL1;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          job_d   = job_e'(job_q + 4'd1);
          state_d = ST_MUL1;
        end
      end
      ST_COMMIT: state_d = ST_OUT;
      ST_OUT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control, configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_DET;
      out_valid_q <= 1'b0;
      qlat_q      <= QLatRst;
      qlon_q      <= QLonRst;
      qx_q        <= QxRst;
      rlat_q      <= RLatRst;
      rlon_q      <= RLonRst;
      rx_q        <= RxRst;
      pinit_q     <= PInitRst;
      p_q[0]      <= {1'b0, PInitRst};
      p_q[1]      <= '0;
      p_q[2]      <= '0;
      p_q[3]      <= {1'b0, PInitRst};
      pos_lat_q   <= '0;
      pos_lon_q   <= '0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_QLAT: qlat_q <= cfg_data_i[30:0];
          REG_QLON: qlon_q <= cfg_data_i[30:0];
          REG_QX:   qx_q   <= cfg_data_i;
          REG_RLAT: rlat_q <= cfg_data_i[30:0];
          REG_RLON: rlon_q <= cfg_data_i[30:0];
          REG_RX:   rx_q   <= cfg_data_i;
          REG_PINIT: begin
            // new initial variance also reloads the covariance
            pinit_q <= cfg_data_i[30:0];
            p_q[0]  <= {1'b0, cfg_data_i[30:0]};
            p_q[1]  <= '0;
            p_q[2]  <= '0;
            p_q[3]  <= {1'b0, cfg_data_i[30:0]};
          end
          default: begin
            pinit_q <= pinit_q;
          end
        endcase
      end else if (state_q == ST_PRED) begin
        p_q[0] <= sat32(sx67(p_q[0]) + ux67(qlat_q));
        p_q[1] <= sat32(sx67(p_q[1]) + sx67(qx_q));
        p_q[2] <= sat32(sx67(p_q[2]) + sx67(qx_q));
        p_q[3] <= sat32(sx67(p_q[3]) + ux67(qlon_q));
      end else if (state_q == ST_COMMIT) begin
        p_q       <= np_q;
        pos_lat_q <= npos_lat_q;
        pos_lon_q <= npos_lon_q;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q[0] <= sx33(meas_lat_i) - sx33(pos_lat_q);
      res_q[1] <= sx33(meas_lon_i) - sx33(pos_lon_q);
      sing_q   <= 1'b0;
    end
    case (state_q)
      ST_SUM: begin
        s_q[0] <= sat32(sx67(p_q[0]) + ux67(rlat_q));
        s_q[1] <= sat32(sx67(p_q[1]) + sx67(rx_q));
        s_q[2] <= sat32(sx67(p_q[2]) + sx67(rx_q));
        s_q[3] <= sat32(sx67(p_q[3]) + ux67(rlon_q));
      end
      ST_MUL1: prod_q <= prod_d;
      ST_MUL2: begin
        acc_q  <= term;
        prod_q <= prod_d;
      end
      ST_MUL3: acc_q <= sub_mode ? (acc_q - term) : (acc_q + term);
      ST_EVAL: begin
        case (job_q)
          JOB_DET: begin
            sing_q    <= acc_zero;
            det_neg_q <= acc_neg;
            det_mag_q <= acc_abs[DivW-1:0];
          end
          JOB_M00, JOB_M01, JOB_M10, JOB_M11: begin
            kneg_q <= acc_neg != det_neg_q;
          end
          JOB_PLAT: npos_lat_q <= sat32(sx67(pos_lat_q) + acc_q);
          JOB_PLON: npos_lon_q <= sat32(sx67(pos_lon_q) + acc_q);
          JOB_C00:  np_q[0] <= sat32(sx67(p_q[0]) - rnd30(acc_q));
          JOB_C01:  np_q[1] <= sat32(sx67(p_q[1]) - rnd30(acc_q));
          JOB_C10:  np_q[2] <= sat32(sx67(p_q[2]) - rnd30(acc_q));
          JOB_C11:  np_q[3] <= sat32(sx67(p_q[3]) - rnd30(acc_q));
          default: begin
            kneg_q <= kneg_q;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          case (job_q)
            JOB_M00: k_q[0] <= kneg_q ? -{1'b0, quot} : {1'b0, quot};
            JOB_M01: k_q[1] <= kneg_q ? -{1'b0, quot} : {1'b0, quot};
            JOB_M10: k_q[2] <= kneg_q ? -{1'b0, quot} : {1'b0, quot};
            JOB_M11: k_q[3] <= kneg_q ? -{1'b0, quot} : {1'b0, quot};
            default: begin
              kneg_q <= kneg_q;
            end
          endcase
        end
      end
      default: begin
        kneg_q <= kneg_q;
      end
    endcase
    if (load_out) begin
      // the committed position is shown; after a full update it already holds the new estimate
      est_lat_q  <= (state_q == ST_OUT) ? pos_lat_q : est_lat_q;
      est_lon_q  <= pos_lon_q;
      sing_out_q <= sing_q;
    end
  end

  // gain divider, magnitudes only
  pkf2d_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (acc_abs[DivW-1:0]),
    .den_i  (det_mag_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign out_valid_o = out_valid_q;
  assign est_lat_o   = est_lat_q;
  assign est_lon_o   = est_lon_q;
  assign singular_o  = sing_out_q;

endmodule

@@ design/pkf2d_div.sv @@
// restoring divider for the kalman gain: floor(num * 2^30 / den), saturated
// uses pkf2d_pkg
module pkf2d_div import pkf2d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DivW-1:0]   num_i,
  input  logic [DivW-1:0]   den_i,
  output logic              done_o,
  output logic [QuotW-1:0]  quot_o
);

  localparam int CntW = $clog2(QuotW);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [DivW:0]     rem_q;
  logic [DivW-1:0]   den_q;
  logic [QuotW-1:0]  quot_q;
  logic              fits;
  logic [DivW:0]     rem_n;
  logic              ovf;

  // quotient reaches 2^31 exactly when num >= 2 * den
  assign ovf   = {1'b0, num_i} >= {den_i, 1'b0};
  assign fits  = rem_q >= {1'b0, den_q};
  assign rem_n = fits ? (rem_q - {1'b0, den_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !ovf;
        done_q <= ovf;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QuotW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= ovf ? {QuotW{1'b1}} : '0;
    end else if (busy_q) begin
      rem_q  <= {rem_n[DivW-1:0], 1'b0};
      quot_q <= {quot_q[QuotW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ design/pkf2d_chk.sv @@
// port-level checker for the 2d position kalman filter core, with its bind
// depends on position_kalman_filter_2d_core through the bind
module pkf2d_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] est_lat_o,
  input logic signed [31:0] est_lon_o,
  input logic               singular_o
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(est_lat_o) && $stable(est_lon_o)
                                    && $stable(singular_o))
    else $error("stalled result changed");

  // one item at a time
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // a new result only comes out of a busy cycle
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without work");

endmodule

bind position_kalman_filter_2d_core pkf2d_chk u_chk (.*);
